// File: design/lwdb_pkg.sv
// shared types, constants and codes for the liveness watchdog with backoff
`timescale 1ns / 1ps

package lwdb_pkg;

    localparam int TIME_BITS_DEF = 32;

    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CNT_W       = 8;
    localparam int SEC_W       = 16;
    localparam int PROD_W      = 20;
    localparam int LIM_W       = 18;
    localparam int DL_W        = 17;
    localparam int DIV_W       = 15;
    localparam int REM_W       = 14;
    localparam int RND_W       = 32;
    localparam int STEP_W      = 5;
    localparam int FIELD_T_W   = 32;
    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 88;
    localparam int OUT_TUSER_W = 3;

    localparam logic [CNT_W-1:0] NOREG_RST     = 8'd0;
    localparam logic [SEC_W-1:0] KEEPALIVE_RST = 16'd300;
    localparam logic [SEC_W-1:0] FLOOR_RST     = 16'd480;
    localparam logic [SEC_W-1:0] GRACE_RST     = 16'd60;
    localparam logic [SEC_W-1:0] BASE_RST      = 16'd300;
    localparam logic [SEC_W-1:0] CAP_RST       = 16'd3600;
    localparam logic [CNT_W-1:0] MAX_NOREG_RST = 8'd5;

    localparam logic [CNT_W-1:0] NOREG_FLAT_MIN = 8'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NOREG_COUNT,
        CFG_KEEPALIVE,
        CFG_SILENCE_FLOOR,
        CFG_BOOT_GRACE,
        CFG_BASE_DEADLINE,
        CFG_BACKOFF_CAP,
        CFG_MAX_NOREG
    } cfg_idx_t;

    typedef enum logic [IN_TUSER_W-1:0] {
        ACT_START,
        ACT_EMIT,
        ACT_CHECK,
        ACT_CHECK_ALT
    } action_t;

    typedef enum logic [OUT_TUSER_W-1:0] {
        VD_STARTED,
        VD_EMITTED,
        VD_NOT_STARTED,
        VD_WAITING,
        VD_COLD_REBOOT,
        VD_NUDGE_ONLY,
        VD_IN_GRACE,
        VD_HEALTHY
    } verdict_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_REG_TIMEOUT,
        ERR_SILENCE
    } err_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_RES
    } state_t;

    typedef struct packed {
        logic load_item;
        logic load_cap;
        logic div_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic is_start;
        logic out_free;
    } status_t;

endpackage

// File: design/liveness_watchdog_backoff.sv
// Liveness watchdog with exponential registration backoff.
// Requests arrive on the s_ channel: tuser carries the action (start, emit,
// check), tdata carries uptime and a random word. Each request produces
// exactly one result on the m_ channel: tuser is the verdict, tdata carries
// the flags, error kind, deadline, silence and last emit time.
// A start computes the backed-off deadline and its jitter with a serial
// remainder unit, one dividend bit per cycle, before the result register
// is loaded. Emit and check requests skip the remainder unit.
// One request is worked on at a time; the next request is taken once the
// result sits in the output register, even if the receiver has not yet
// taken it. A stalled m_ side holds the result and blocks only the commit
// of the following request.
// Configuration is written through cfg_wr_en/cfg_wr_index/cfg_wr_data and
// takes effect on the next edge; writes are expected while idle.
// Reset (aresetn low, synchronous) restores register defaults, clears the
// start flag, the last emit time and the deadline, and empties the output.
`timescale 1ns / 1ps

module liveness_watchdog_backoff #(
    parameter int TIME_BITS = lwdb_pkg::TIME_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [lwdb_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [lwdb_pkg::CFG_W-1:0]       cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // uptime, random_word
    input  logic [lwdb_pkg::IN_TDATA_W-1:0]  s_tdata,
    // action
    input  logic [lwdb_pkg::IN_TUSER_W-1:0]  s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // recover_request, bump_noreg_count, bump_recover_count, error_kind,
    // deadline_s, silence, stored emit time, zero pad
    output logic [lwdb_pkg::OUT_TDATA_W-1:0] m_tdata,
    // verdict
    output logic [lwdb_pkg::OUT_TUSER_W-1:0] m_tuser
);
    import lwdb_pkg::*;

    cmd_t    cmd;
    status_t status;

    lwdb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lwdb_datapath #(
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .cmd          (cmd),
        .status       (status),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

endmodule

// File: design/lwdb_ctrl.sv
// controller state machine: request intake, jitter modulo sequencing, result commit
`timescale 1ns / 1ps

module lwdb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  lwdb_pkg::status_t status,
    output lwdb_pkg::cmd_t    cmd
);
    import lwdb_pkg::*;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(RND_W - 1);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.load_cap = 1'b1;
                step_next    = '0;
                state_next   = status.is_start ? ST_DIV : ST_RES;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST) begin
                    state_next = ST_RES;
                end
            end
            ST_RES: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/lwdb_datapath.sv
// datapath: config registers, watchdog state, backoff and jitter modulo, result register
`timescale 1ns / 1ps

module lwdb_datapath #(
    parameter int TIME_BITS = lwdb_pkg::TIME_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [lwdb_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [lwdb_pkg::CFG_W-1:0]      cfg_wr_data,
    input  logic [lwdb_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic [lwdb_pkg::IN_TUSER_W-1:0] s_tuser,
    input  lwdb_pkg::cmd_t                  cmd,
    output lwdb_pkg::status_t               status,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [lwdb_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [lwdb_pkg::OUT_TUSER_W-1:0] m_tuser
);
    import lwdb_pkg::*;

    localparam int TW    = (TIME_BITS < FIELD_T_W) ? TIME_BITS : FIELD_T_W;
    localparam int CMP_W = (TIME_BITS > LIM_W) ? TIME_BITS : LIM_W;

    // configuration
    logic [CNT_W-1:0] noreg_reg, maxnr_reg;
    logic [SEC_W-1:0] keep_reg, floor_reg, grace_reg, base_reg, cap_reg;

    // watchdog state
    logic [TW-1:0]    last_reg;
    logic [DL_W-1:0]  dl_reg;
    logic             started_reg;
    logic             out_valid_reg;

    // request and working registers
    action_t          act_reg;
    logic [TW-1:0]    now_reg;
    logic [RND_W-1:0] rnd_reg;
    logic [SEC_W-1:0] dcap_reg;
    logic [REM_W-1:0] rem_reg;

    // result payload
    verdict_t             verdict_reg;
    logic                 rec_reg, bnr_reg, brc_reg;
    err_t                 err_reg;
    logic [DL_W-1:0]      dlo_reg;
    logic [FIELD_T_W-1:0] sil_reg, lasto_reg;

    logic [PROD_W-1:0]    prod;
    logic [SEC_W-1:0]     dcap_next;
    logic [DIV_W-1:0]     divisor, trial, rem_step;
    logic [DL_W-1:0]      new_dl;
    logic [LIM_W-1:0]     lim3, limit;
    logic [TIME_BITS-1:0] silence;
    logic [FIELD_T_W-1:0] now_ext;

    verdict_t             verdict_next;
    logic                 rec_next, bnr_next, brc_next;
    err_t                 err_next;
    logic [DL_W-1:0]      dlo_next;
    logic [FIELD_T_W-1:0] sil_next, lasto_next;

    // backoff multiplier 1, 2, 4, 8, then flat 12
    always_comb begin
        if (noreg_reg >= NOREG_FLAT_MIN) begin
            prod = (PROD_W'(base_reg) << 3) + (PROD_W'(base_reg) << 2);
        end else begin
            prod = PROD_W'(base_reg) << noreg_reg[1:0];
        end
        dcap_next = (prod > PROD_W'(cap_reg)) ? cap_reg : prod[SEC_W-1:0];
    end

    // restoring remainder, one dividend bit per step
    always_comb begin
        divisor  = DIV_W'(dcap_reg[SEC_W-1:2]) + DIV_W'(1);
        trial    = {rem_reg, rnd_reg[RND_W-1]};
        rem_step = (trial >= divisor) ? (trial - divisor) : trial;
        new_dl   = DL_W'(dcap_reg) + DL_W'(rem_reg);
    end

    always_comb begin
        lim3    = (LIM_W'(keep_reg) << 1) + LIM_W'(keep_reg);
        limit   = (lim3 < LIM_W'(floor_reg)) ? LIM_W'(floor_reg) : lim3;
        silence = TIME_BITS'(now_reg) - TIME_BITS'(last_reg);
        now_ext = FIELD_T_W'(now_reg);
    end

    always_comb begin
        verdict_next = VD_STARTED;
        rec_next     = 1'b0;
        bnr_next     = 1'b0;
        brc_next     = 1'b0;
        err_next     = ERR_NONE;
        dlo_next     = dl_reg;
        sil_next     = '0;
        lasto_next   = FIELD_T_W'(last_reg);
        case (act_reg)
            ACT_START: begin
                verdict_next = VD_STARTED;
                dlo_next     = new_dl;
            end
            ACT_EMIT: begin
                verdict_next = VD_EMITTED;
                lasto_next   = now_ext;
            end
            default: begin
                if (!started_reg) begin
                    verdict_next = VD_NOT_STARTED;
                end else if (last_reg == '0) begin
                    if (now_ext >= FIELD_T_W'(dl_reg)) begin
                        if (noreg_reg >= maxnr_reg) begin
                            verdict_next = VD_NUDGE_ONLY;
                            rec_next     = 1'b1;
                        end else begin
                            verdict_next = VD_COLD_REBOOT;
                            bnr_next     = 1'b1;
                            err_next     = ERR_REG_TIMEOUT;
                        end
                    end else begin
                        verdict_next = VD_WAITING;
                    end
                end else if (now_ext < FIELD_T_W'(grace_reg)) begin
                    verdict_next = VD_IN_GRACE;
                end else begin
                    verdict_next = VD_HEALTHY;
                    sil_next     = FIELD_T_W'(silence);
                    if (CMP_W'(silence) > CMP_W'(limit)) begin
                        rec_next = 1'b1;
                        brc_next = 1'b1;
                        err_next = ERR_SILENCE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            noreg_reg     <= NOREG_RST;
            keep_reg      <= KEEPALIVE_RST;
            floor_reg     <= FLOOR_RST;
            grace_reg     <= GRACE_RST;
            base_reg      <= BASE_RST;
            cap_reg       <= CAP_RST;
            maxnr_reg     <= MAX_NOREG_RST;
            last_reg      <= '0;
            dl_reg        <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_wr_index))
                    CFG_NOREG_COUNT:   noreg_reg <= cfg_wr_data[CNT_W-1:0];
                    CFG_KEEPALIVE:     keep_reg  <= cfg_wr_data[SEC_W-1:0];
                    CFG_SILENCE_FLOOR: floor_reg <= cfg_wr_data[SEC_W-1:0];
                    CFG_BOOT_GRACE:    grace_reg <= cfg_wr_data[SEC_W-1:0];
                    CFG_BASE_DEADLINE: base_reg  <= cfg_wr_data[SEC_W-1:0];
                    CFG_BACKOFF_CAP:   cap_reg   <= cfg_wr_data[SEC_W-1:0];
                    CFG_MAX_NOREG:     maxnr_reg <= cfg_wr_data[CNT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (cmd.commit) begin
                out_valid_reg <= 1'b1;
                if (act_reg == ACT_START) begin
                    dl_reg      <= new_dl;
                    started_reg <= 1'b1;
                end else if (act_reg == ACT_EMIT) begin
                    last_reg <= now_reg;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            act_reg <= action_t'(s_tuser);
            now_reg <= s_tdata[TW-1:0];
            rnd_reg <= s_tdata[FIELD_T_W +: RND_W];
        end else if (cmd.div_step) begin
            rnd_reg <= {rnd_reg[RND_W-2:0], 1'b0};
        end
        if (cmd.load_cap) begin
            dcap_reg <= dcap_next;
            rem_reg  <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= rem_step[REM_W-1:0];
        end
        if (cmd.commit) begin
            verdict_reg <= verdict_next;
            rec_reg     <= rec_next;
            bnr_reg     <= bnr_next;
            brc_reg     <= brc_next;
            err_reg     <= err_next;
            dlo_reg     <= dlo_next;
            sil_reg     <= sil_next;
            lasto_reg   <= lasto_next;
        end
    end

    assign status.is_start = (act_reg == ACT_START);
    assign status.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, lasto_reg, sil_reg, dlo_reg, err_reg, brc_reg, bnr_reg, rec_reg};
    assign m_tuser  = verdict_reg;

endmodule

// File: tb/sv/liveness_watchdog_backoff_tb.sv
// self-checking testbench for the liveness watchdog with registration backoff
`timescale 1ns / 1ps

module liveness_watchdog_backoff_tb;

    import lwdb_pkg::*;

    typedef struct {
        verdict_t          verdict;
        logic              recover;
        logic              bump_noreg;
        logic              bump_rec;
        err_t              err;
        logic [DL_W-1:0]   deadline;
        logic [31:0]       silence;
        logic [31:0]       emit_time;
    } wd_result_t;

    class watchdog_scoreboard;
        logic [CNT_W-1:0] noreg_cnt;
        logic [CNT_W-1:0] max_noreg;
        logic [SEC_W-1:0] keepalive;
        logic [SEC_W-1:0] floor_s;
        logic [SEC_W-1:0] grace;
        logic [SEC_W-1:0] base_dl;
        logic [SEC_W-1:0] cap_dl;
        logic [31:0]      emit_time;
        logic [DL_W-1:0]  deadline;
        bit               started;
        wd_result_t       awaited_q[$];
        int               mismatches;

        function new();
            noreg_cnt  = NOREG_RST;
            max_noreg  = MAX_NOREG_RST;
            keepalive  = KEEPALIVE_RST;
            floor_s    = FLOOR_RST;
            grace      = GRACE_RST;
            base_dl    = BASE_RST;
            cap_dl     = CAP_RST;
            emit_time  = '0;
            deadline   = '0;
            started    = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_NOREG_COUNT:   noreg_cnt = val[CNT_W-1:0];
                CFG_KEEPALIVE:     keepalive = val;
                CFG_SILENCE_FLOOR: floor_s   = val;
                CFG_BOOT_GRACE:    grace     = val;
                CFG_BASE_DEADLINE: base_dl   = val;
                CFG_BACKOFF_CAP:   cap_dl    = val;
                CFG_MAX_NOREG:     max_noreg = val[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned silence_limit();
            longint unsigned lim;
            lim = 64'(keepalive) * 3;
            if (lim < 64'(floor_s)) lim = 64'(floor_s);
            return lim;
        endfunction

        function logic [DL_W-1:0] backoff_deadline(logic [31:0] rnd);
            longint unsigned mult;
            longint unsigned d;
            mult = (noreg_cnt >= NOREG_FLAT_MIN) ? 64'd12 : (64'd1 << noreg_cnt);
            d = 64'(base_dl) * mult;
            if (d > 64'(cap_dl)) d = 64'(cap_dl);
            d = d + 64'(rnd) % (d / 4 + 1);
            return d[DL_W-1:0];
        endfunction

        function void note_request(action_t act, logic [31:0] up, logic [31:0] rnd);
            wd_result_t r;
            r.verdict    = VD_STARTED;
            r.recover    = 1'b0;
            r.bump_noreg = 1'b0;
            r.bump_rec   = 1'b0;
            r.err        = ERR_NONE;
            r.silence    = '0;
            case (act)
                ACT_START: begin
                    deadline  = backoff_deadline(rnd);
                    started   = 1'b1;
                    r.verdict = VD_STARTED;
                end
                ACT_EMIT: begin
                    emit_time = up;
                    r.verdict = VD_EMITTED;
                end
                default: begin
                    if (!started) begin
                        r.verdict = VD_NOT_STARTED;
                    end else if (emit_time == 0) begin
                        if (up >= 32'(deadline)) begin
                            if (noreg_cnt >= max_noreg) begin
                                r.verdict = VD_NUDGE_ONLY;
                                r.recover = 1'b1;
                            end else begin
                                r.verdict    = VD_COLD_REBOOT;
                                r.bump_noreg = 1'b1;
                                r.err        = ERR_REG_TIMEOUT;
                            end
                        end else begin
                            r.verdict = VD_WAITING;
                        end
                    end else if (up < 32'(grace)) begin
                        r.verdict = VD_IN_GRACE;
                    end else begin
                        r.silence = up - emit_time;
                        r.verdict = VD_HEALTHY;
                        if (64'(r.silence) > silence_limit()) begin
                            r.recover  = 1'b1;
                            r.bump_rec = 1'b1;
                            r.err      = ERR_SILENCE;
                        end
                    end
                end
            endcase
            r.deadline  = deadline;
            r.emit_time = emit_time;
            awaited_q.push_back(r);
        endfunction

        task report(string field, logic [31:0] got, logic [31:0] want);
            if (mismatches < 40)
                $display("mismatch %s: got %0h want %0h at %0t", field, got, want, $realtime);
            mismatches++;
        endtask

        task check_result(logic [OUT_TUSER_W-1:0] vd, logic [OUT_TDATA_W-1:0] data);
            wd_result_t e;
            if (awaited_q.size() == 0) begin
                report("unexpected result", 32'(vd), 0);
                return;
            end
            e = awaited_q.pop_front();
            if (vd !== e.verdict)          report("verdict", 32'(vd), 32'(e.verdict));
            if (data[0] !== e.recover)     report("recover_request", 32'(data[0]), 32'(e.recover));
            if (data[1] !== e.bump_noreg)  report("bump_noreg_count", 32'(data[1]),
                                                  32'(e.bump_noreg));
            if (data[2] !== e.bump_rec)    report("bump_recover_count", 32'(data[2]),
                                                  32'(e.bump_rec));
            if (data[4:3] !== e.err)       report("error_kind", 32'(data[4:3]), 32'(e.err));
            if (data[21:5] !== e.deadline) report("deadline_s", 32'(data[21:5]), 32'(e.deadline));
            if (data[53:22] !== e.silence) report("silence", data[53:22], e.silence);
            if (data[85:54] !== e.emit_time) report("emit_time", data[85:54], e.emit_time);
        endtask
    endclass

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_wr_index = '0;
    logic [CFG_W-1:0]           cfg_wr_data = '0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [IN_TDATA_W-1:0]      s_tdata = '0;
    logic [IN_TUSER_W-1:0]      s_tuser = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]     m_tdata;
    logic [OUT_TUSER_W-1:0]     m_tuser;

    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    watchdog_scoreboard sb;

    liveness_watchdog_backoff dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    always @(negedge aclk) begin
        m_tready <= rx_calm ? 1'b1 : ($urandom_range(0, 99) >= 13);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    end

    task automatic send_req(input action_t act, input logic [31:0] up, input logic [31:0] rnd);
        @(negedge aclk);
        while (!tx_calm && $urandom_range(0, 99) < 13) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rnd, up};
        s_tuser  <= act;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(act, up, rnd);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.awaited_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(negedge aclk);
        cfg_wr_en    <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    function automatic logic [CFG_W-1:0] pick_cfg(int lo, int hi, int typ_hi);
        int j;
        j = $urandom_range(0, 19);
        if (j < 2) return CFG_W'(lo);
        if (j < 4) return CFG_W'(hi);
        if (j == 4) return CFG_W'($urandom);
        if (j == 5) return '0;
        return CFG_W'($urandom_range(lo, typ_hi));
    endfunction

    task automatic random_config();
        logic [CFG_W-1:0] val;
        wait_drained();
        for (int i = 0; i < 7; i++) begin
            if ($urandom_range(0, 9) < 6) begin
                case (cfg_idx_t'(i))
                    CFG_NOREG_COUNT:   val = pick_cfg(0, 255, 6);
                    CFG_KEEPALIVE:     val = pick_cfg(1, 65535, 400);
                    CFG_SILENCE_FLOOR: val = pick_cfg(0, 65535, 2000);
                    CFG_BOOT_GRACE:    val = pick_cfg(0, 65535, 300);
                    CFG_BASE_DEADLINE: val = pick_cfg(1, 65535, 1000);
                    CFG_BACKOFF_CAP:   val = pick_cfg(1, 65535, 8000);
                    default:           val = pick_cfg(0, 255, 6);
                endcase
                cfg_write(cfg_idx_t'(i), val);
            end
        end
    endtask

    task automatic random_item();
        int          k;
        int          j;
        int          off;
        logic [31:0] up;
        logic [31:0] rnd;
        logic [31:0] lim;
        k   = $urandom_range(0, 99);
        j   = $urandom_range(0, 9);
        rnd = $urandom;
        up  = $urandom;
        off = $urandom_range(0, 4);
        off = off - 2;
        lim = 32'(sb.silence_limit());
        if (k < 8) begin
            send_req(action_t'($urandom_range(0, 3)), up, rnd);
        end else if (k < 18) begin
            if (j < 3) rnd = $urandom_range(0, 64);
            send_req(ACT_START, up, rnd);
        end else if (k < 33) begin
            if (j == 0) up = '0;
            else if (j > 1) up = $urandom_range(0, 32'(sb.grace) + 3000);
            send_req(ACT_EMIT, up, rnd);
        end else begin
            if (sb.emit_time == 0) begin
                if (j < 6) up = 32'(sb.deadline) + off;
                else if (j < 9) up = $urandom_range(0, 2 * 32'(sb.deadline) + 2);
            end else begin
                case (j)
                    0, 1, 2: up = sb.emit_time + lim + off;
                    3, 4:    up = 32'(sb.grace) + off;
                    5, 6:    up = sb.emit_time + $urandom_range(0, 2 * lim);
                    8:       up = sb.emit_time + off;
                    9:       up = sb.emit_time - $urandom_range(1, 100);
                    default: ;
                endcase
            end
            send_req(($urandom_range(0, 9) == 0) ? ACT_CHECK_ALT : ACT_CHECK, up, rnd);
        end
    endtask

    task automatic directed_part();
        // reset settings: deadline 300 plus jitter, silence limit 900, grace 60
        send_req(ACT_CHECK, 32'd100, 32'd0);
        send_req(ACT_CHECK_ALT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(ACT_EMIT, 32'd0, 32'd0);
        send_req(ACT_START, 32'd0, 32'd0);
        send_req(ACT_CHECK, 32'd299, 32'd0);
        send_req(ACT_CHECK, 32'd300, 32'd0);
        send_req(ACT_START, 32'd0, 32'hFFFF_FFFF);
        send_req(ACT_CHECK, 32'hFFFF_FFFF, 32'd0);
        send_req(ACT_EMIT, 32'd50, 32'd0);
        send_req(ACT_CHECK, 32'd59, 32'd0);
        send_req(ACT_CHECK, 32'd950, 32'd0);
        send_req(ACT_CHECK_ALT, 32'd951, 32'd0);
        send_req(ACT_EMIT, 32'hFFFF_FFFF, 32'd0);
        send_req(ACT_CHECK, 32'd100, 32'd0);
        send_req(ACT_START, 32'd7, 32'd12345);
        send_req(ACT_EMIT, 32'd0, 32'hFFFF_FFFF);
        send_req(ACT_CHECK, 32'd5000, 32'd0);

        wait_drained();
        cfg_write(CFG_NOREG_COUNT, 16'd255);
        cfg_write(CFG_KEEPALIVE, 16'd65535);
        cfg_write(CFG_SILENCE_FLOOR, 16'd0);
        cfg_write(CFG_BOOT_GRACE, 16'd0);
        cfg_write(CFG_BASE_DEADLINE, 16'd65535);
        cfg_write(CFG_BACKOFF_CAP, 16'd65535);
        cfg_write(CFG_MAX_NOREG, 16'd255);
        send_req(ACT_START, 32'd0, 32'hFFFF_FFFF);
        send_req(ACT_CHECK, 32'd81918, 32'd0);
        send_req(ACT_EMIT, 32'd1, 32'd0);
        send_req(ACT_CHECK, 32'd0, 32'd0);

        // out of range settings: zero deadline, zero keepalive
        wait_drained();
        cfg_write(CFG_NOREG_COUNT, 16'd4);
        cfg_write(CFG_KEEPALIVE, 16'd0);
        cfg_write(CFG_SILENCE_FLOOR, 16'd65535);
        cfg_write(CFG_BOOT_GRACE, 16'd65535);
        cfg_write(CFG_BASE_DEADLINE, 16'd0);
        cfg_write(CFG_BACKOFF_CAP, 16'd0);
        cfg_write(CFG_MAX_NOREG, 16'd0);
        send_req(ACT_START, 32'd0, $urandom);
        send_req(ACT_EMIT, 32'd0, 32'd0);
        send_req(ACT_CHECK, 32'd0, 32'd0);
        send_req(ACT_EMIT, 32'd10, 32'd0);
        send_req(ACT_CHECK, 32'd65545, 32'd0);
        send_req(ACT_CHECK, 32'd131081, 32'd0);
    endtask

    initial begin
        int n;
        int len;
        sb = new();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        directed_part();

        n = 0;
        while (n < 1600) begin
            if (n == 0 || $urandom_range(0, 1)) random_config();
            tx_calm = (n >= 500 && n < 800);
            rx_calm = tx_calm;
            send_req(ACT_START, $urandom, $urandom);
            len = $urandom_range(4, 20);
            repeat (len) random_item();
            n = n + len + 1;
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        wait_drained();
        repeat (40) @(posedge aclk);
        if (sb.mismatches == 0 && sb.awaited_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
